// ===== src/bbe_pkg.sv =====
// ----------------------------------------------------------------------------
// bbe_pkg: shared types and constants of the edge-aware 3x3 box blur
// Pixel layout, window geometry, divider reciprocals and lane-to-merge types.
// ----------------------------------------------------------------------------
`default_nettype none

package bbe_pkg;

  // Channels: one lane per channel
  localparam int CH_W     = 8;
  localparam int NUM_CH   = 3;
  localparam int CH_RED   = 2;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 0;

  typedef logic [NUM_CH-1:0][CH_W-1:0] pix_t;

  // 3x3 window, cell index is row * WIN_DIM + column, row 0 oldest
  localparam int WIN_DIM   = 3;
  localparam int WIN_CELLS = WIN_DIM * WIN_DIM;

  // Configuration
  localparam int CFG_W          = 11;
  localparam int FRAME_RST      = 1024;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Mean arithmetic: q = (2*sum + n) / (2*n) via reciprocal multiply
  localparam int SUM_W       = 12;
  localparam int CNT_W       = 4;
  localparam int NUM_W       = 13;
  localparam int RECIP_W     = 18;
  localparam int RECIP_SHIFT = 18;
  localparam int PROD_W      = NUM_W + RECIP_W;

  // Result queue behind the lanes
  localparam int QUEUE_DEPTH = 4;
  localparam int QAW         = $clog2(QUEUE_DEPTH);
  localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic valid;
    logic frame_end;
  } issue_t;

  typedef struct packed {
    logic frame_end;
    pix_t pix;
  } result_t;

  // ceil(2^18 / (2n)); exact floor division for numerators below 4600
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] m;
    case (cnt)
      CNT_W'(1): m = RECIP_W'(131072);
      CNT_W'(2): m = RECIP_W'(65536);
      CNT_W'(3): m = RECIP_W'(43691);
      CNT_W'(4): m = RECIP_W'(32768);
      CNT_W'(5): m = RECIP_W'(26215);
      CNT_W'(6): m = RECIP_W'(21846);
      CNT_W'(7): m = RECIP_W'(18725);
      CNT_W'(8): m = RECIP_W'(16384);
      CNT_W'(9): m = RECIP_W'(14564);
      default:   m = '0;
    endcase
    return m;
  endfunction

  // Number of cells in the lower-right block starting at (row_lo, col_lo)
  function automatic logic [CNT_W-1:0] cell_count(input logic [1:0] row_lo,
                                                  input logic [1:0] col_lo);
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] cols;
    rows = CNT_W'(2'd3 - row_lo);
    cols = CNT_W'(2'd3 - col_lo);
    return CNT_W'(rows * cols);
  endfunction

endpackage

`default_nettype wire

// ===== src/bbe_line_store.sv =====
// ----------------------------------------------------------------------------
// bbe_line_store: one row of pixels
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bbe_line_store import bbe_pkg::*; #(
  parameter int DEPTH = DEF_MAX_WIDTH,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire pix_t          wdata,
  input  wire logic [AW-1:0] raddr,
  output pix_t               rdata
);

  pix_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/bbe_lane.sv =====
// ----------------------------------------------------------------------------
// bbe_lane: one colour channel of the blur
// Masked window sum, then rounded mean by reciprocal multiply; two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module bbe_lane import bbe_pkg::*; (
  input  wire logic                 clk,
  input  wire logic [CH_W-1:0]      chan_in [WIN_CELLS],
  input  wire logic [WIN_CELLS-1:0] mask,
  input  wire logic [CNT_W-1:0]     cnt,
  output logic      [CH_W-1:0]      quot
);

  logic [SUM_W-1:0]   sum;
  logic [NUM_W-1:0]   num_r;
  logic [RECIP_W-1:0] recip_r;
  logic [PROD_W-1:0]  prod_r;

  always_comb begin
    sum = '0;
    for (int i = 0; i < WIN_CELLS; i++) begin
      sum = sum + SUM_W'(mask[i] ? chan_in[i] : '0);
    end
  end

  // numerator 2*sum + n rounds half up after the divide by 2n
  always_ff @(posedge clk) begin
    num_r   <= NUM_W'({sum, 1'b0}) + NUM_W'(cnt);
    recip_r <= recip(cnt);
    prod_r  <= PROD_W'(num_r) * PROD_W'(recip_r);
  end

  assign quot = prod_r[RECIP_SHIFT +: CH_W];

endmodule

`default_nettype wire

// ===== src/bbe_merge.sv =====
// ----------------------------------------------------------------------------
// bbe_merge: joins the lane results into output transactions
// Tracks lane latency, queues finished pixels and grants issue credits.
// ----------------------------------------------------------------------------
`default_nettype none

module bbe_merge import bbe_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire issue_t          issue,
  input  wire logic [CH_W-1:0] quot [NUM_CH],
  output logic                 can_issue,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output pix_t                 out_pix,
  output logic                 out_frame_end
);

  logic           vld_d1_r, vld_d2_r;
  logic           end_d1_r, end_d2_r;
  result_t        q_mem_r [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0] fill_r, fill_nxt;
  logic [QCW-1:0] pending_r, pending_nxt;
  logic           push, pop;
  result_t        entry;

  assign push = vld_d2_r;
  assign pop  = out_valid && out_ready;

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      entry.pix[c] = quot[c];
    end
    entry.frame_end = end_d2_r;
  end

  always_comb begin
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
    // credits cover everything issued and not yet taken
    pending_nxt = pending_r;
    if (issue.valid && !pop) begin
      pending_nxt = pending_r + 1'b1;
    end else if (pop && !issue.valid) begin
      pending_nxt = pending_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d1_r  <= 1'b0;
      vld_d2_r  <= 1'b0;
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      fill_r    <= '0;
      pending_r <= '0;
    end else begin
      vld_d1_r  <= issue.valid;
      vld_d2_r  <= vld_d1_r;
      fill_r    <= fill_nxt;
      pending_r <= pending_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    end_d1_r <= issue.frame_end;
    end_d2_r <= end_d1_r;
    if (push) begin
      q_mem_r[wr_ptr_r] <= entry;
    end
  end

  assign can_issue     = pending_r < QCW'(QUEUE_DEPTH);
  assign out_valid     = fill_r != '0;
  assign out_pix       = q_mem_r[rd_ptr_r].pix;
  assign out_frame_end = q_mem_r[rd_ptr_r].frame_end;

endmodule

`default_nettype wire

// ===== src/box_blur_3x3_edge_aware_core.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware_core: edge-aware 3x3 box blur of an RGB frame
// Pixels arrive in raster order; each output is the rounded-half-up mean of
// the in-frame pixels of its 3x3 neighbourhood, per channel.
//
// Input channel (in_valid/in_ready): in_req_type low carries a pixel, high a
// drain step; once the last pixel of the frame is in, one drain step per
// column emits the final row. Output row r comes out while row r+1 arrives.
// Output channel (out_valid/out_ready): one blurred pixel per transaction,
// out_frame_end on the last pixel of the frame.
// Sequencing: a pixel passes an accept step, a load step and one emit step
// per result it produces; a drain step passes an accept step, one fetch step
// per line-store column read, a tail step and one emit step. Both sequences
// are set by the single read port of each line store and the three channel
// lanes, which take one result per cycle. Each result then passes the lane
// registers and a 4-entry result queue that absorbs receiver stalls; the block
// keeps taking transactions until it has no room left for the results in flight.
// Reset restores 1024 x 1024 and the start of a frame; a configuration
// write does the same with the new size. Line stores need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_3x3_edge_aware_core import bbe_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             in_req_type,
  input  wire logic [CH_W-1:0]  in_red,
  input  wire logic [CH_W-1:0]  in_green,
  input  wire logic [CH_W-1:0]  in_blue,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [CH_W-1:0]  out_red,
  output logic      [CH_W-1:0]  out_green,
  output logic      [CH_W-1:0]  out_blue,
  output logic                  out_frame_end,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int RW     = $clog2(MAX_HEIGHT + 1);
  localparam int WCMP_W = (WW > CFG_W) ? WW : CFG_W;
  localparam int HCMP_W = (RW > CFG_W) ? RW : CFG_W;
  localparam int W_RST  = (MAX_WIDTH < FRAME_RST) ? MAX_WIDTH : FRAME_RST;
  localparam int H_RST  = (MAX_HEIGHT < FRAME_RST) ? MAX_HEIGHT : FRAME_RST;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_TAIL  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  // control
  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] drain_col_r, drain_col_nxt;
  logic [WW-1:0] eff_w_r, eff_w_nxt;
  logic [RW-1:0] eff_h_r, eff_h_nxt;
  logic          emit_a_r, emit_a_nxt;
  logic          emit_b_r, emit_b_nxt;
  logic          drain_r, drain_nxt;
  logic          end_r, end_nxt;
  logic          shift_en_r, shift_en_nxt;

  // per-transaction payload
  pix_t          px_r, px_nxt;
  logic [CW-1:0] col_r, col_nxt;
  logic          row1_r, row1_nxt;
  logic          row2_r, row2_nxt;
  logic [1:0]    col_lo_a_r, col_lo_a_nxt;
  logic [1:0]    col_lo_b_r, col_lo_b_nxt;
  logic [1:0]    row_lo_r, row_lo_nxt;
  logic [CW-1:0] fetch_col_r, fetch_col_nxt;
  logic [CW-1:0] fetch_end_r, fetch_end_nxt;
  pix_t          window_r [WIN_CELLS];
  pix_t          window_nxt [WIN_CELLS];

  logic [WW-1:0]        w_last_full;
  logic [CW-1:0]        w_last;
  logic                 draining;
  logic [CW-1:0]        rd_addr;
  logic                 upper_we, lower_we;
  pix_t                 upper_rd, lower_rd;
  logic [1:0]           col_sel;
  logic [WIN_CELLS-1:0] win_mask;
  logic [CNT_W-1:0]     win_cnt;
  issue_t               issue;
  logic                 can_issue;
  logic [CH_W-1:0]      quot [NUM_CH];
  pix_t                 out_pix;
  logic [WCMP_W-1:0]    w_cfg_ext;
  logic [HCMP_W-1:0]    h_cfg_ext;

  assign w_last_full = eff_w_r - WW'(1);
  assign w_last      = w_last_full[CW-1:0];
  assign draining    = in_row_r == eff_h_r;
  assign in_ready    = state_r == S_IDLE;
  assign rd_addr     = (state_r == S_FETCH) ? fetch_col_r : in_col_r;

  // ---------------------------------------------------------------- line stores
  bbe_line_store #(.DEPTH(MAX_WIDTH), .AW(CW)) u_upper (
    .clk   (clk),
    .we    (upper_we),
    .waddr (col_r),
    .wdata (lower_rd),
    .raddr (rd_addr),
    .rdata (upper_rd)
  );

  bbe_line_store #(.DEPTH(MAX_WIDTH), .AW(CW)) u_lower (
    .clk   (clk),
    .we    (lower_we),
    .waddr (col_r),
    .wdata (px_r),
    .raddr (rd_addr),
    .rdata (lower_rd)
  );

  // ---------------------------------------------------------------- window mask
  assign col_sel = emit_a_r ? col_lo_a_r : col_lo_b_r;
  assign win_cnt = cell_count(row_lo_r, col_sel);

  always_comb begin
    for (int r = 0; r < WIN_DIM; r++) begin
      for (int c = 0; c < WIN_DIM; c++) begin
        win_mask[r*WIN_DIM+c] = (2'(r) >= row_lo_r) && (2'(c) >= col_sel);
      end
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt     = state_r;
    in_col_nxt    = in_col_r;
    in_row_nxt    = in_row_r;
    drain_col_nxt = drain_col_r;
    eff_w_nxt     = eff_w_r;
    eff_h_nxt     = eff_h_r;
    emit_a_nxt    = emit_a_r;
    emit_b_nxt    = emit_b_r;
    drain_nxt     = drain_r;
    end_nxt       = end_r;
    shift_en_nxt  = state_r == S_FETCH;
    px_nxt        = px_r;
    col_nxt       = col_r;
    row1_nxt      = row1_r;
    row2_nxt      = row2_r;
    col_lo_a_nxt  = col_lo_a_r;
    col_lo_b_nxt  = col_lo_b_r;
    row_lo_nxt    = row_lo_r;
    fetch_col_nxt = fetch_col_r;
    fetch_end_nxt = fetch_end_r;
    window_nxt    = window_r;
    upper_we      = 1'b0;
    lower_we      = 1'b0;
    issue         = '0;
    w_cfg_ext     = WCMP_W'(cfg_wdata);
    h_cfg_ext     = HCMP_W'(cfg_wdata);

    // drain columns land in the cycle after their read
    if (shift_en_r) begin
      for (int r = 0; r < WIN_DIM; r++) begin
        window_nxt[r*WIN_DIM]   = window_r[r*WIN_DIM+1];
        window_nxt[r*WIN_DIM+1] = window_r[r*WIN_DIM+2];
      end
      window_nxt[2] = '0;
      window_nxt[5] = upper_rd;
      window_nxt[8] = lower_rd;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!in_req_type) begin
            if (!draining) begin
              px_nxt[CH_RED]   = in_red;
              px_nxt[CH_GREEN] = in_green;
              px_nxt[CH_BLUE]  = in_blue;
              col_nxt          = in_col_r;
              row1_nxt         = in_row_r != '0;
              row2_nxt         = in_row_r > RW'(1);
              emit_a_nxt       = (in_row_r != '0) && (in_col_r != '0);
              emit_b_nxt       = (in_row_r != '0) && (in_col_r == w_last);
              col_lo_a_nxt     = (in_col_r > CW'(1)) ? 2'd0 : 2'd1;
              col_lo_b_nxt     = (in_col_r != '0) ? 2'd1 : 2'd2;
              row_lo_nxt       = (in_row_r > RW'(1)) ? 2'd0 : 2'd1;
              drain_nxt        = 1'b0;
              end_nxt          = 1'b0;
              if (in_col_r == w_last) begin
                in_col_nxt = '0;
                in_row_nxt = in_row_r + 1'b1;
              end else begin
                in_col_nxt = in_col_r + 1'b1;
              end
              state_nxt = S_LOAD;
            end
          end else if (draining) begin
            fetch_col_nxt = (drain_col_r != '0) ? drain_col_r - 1'b1 : drain_col_r;
            fetch_end_nxt = (drain_col_r != w_last) ? drain_col_r + 1'b1 : drain_col_r;
            col_lo_a_nxt  = {1'b0, drain_col_r == '0} + {1'b0, drain_col_r == w_last};
            row_lo_nxt    = (eff_h_r > RW'(1)) ? 2'd1 : 2'd2;
            emit_a_nxt    = 1'b1;
            emit_b_nxt    = 1'b0;
            drain_nxt     = 1'b1;
            end_nxt       = drain_col_r == w_last;
            state_nxt     = S_FETCH;
          end
        end
      end
      S_LOAD: begin
        // first column of a row starts from an empty window
        for (int r = 0; r < WIN_DIM; r++) begin
          window_nxt[r*WIN_DIM]   = (col_r == '0) ? '0 : window_r[r*WIN_DIM+1];
          window_nxt[r*WIN_DIM+1] = (col_r == '0) ? '0 : window_r[r*WIN_DIM+2];
        end
        window_nxt[2] = row2_r ? upper_rd : '0;
        window_nxt[5] = row1_r ? lower_rd : '0;
        window_nxt[8] = px_r;
        upper_we      = row1_r;
        lower_we      = 1'b1;
        state_nxt     = (emit_a_r || emit_b_r) ? S_EMIT : S_IDLE;
      end
      S_FETCH: begin
        fetch_col_nxt = fetch_col_r + 1'b1;
        if (fetch_col_r == fetch_end_r) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (can_issue) begin
          issue.valid     = 1'b1;
          issue.frame_end = end_r;
          if (emit_a_r) begin
            emit_a_nxt = 1'b0;
          end else begin
            emit_b_nxt = 1'b0;
          end
          if (!emit_a_r || !emit_b_r) begin
            state_nxt = S_IDLE;
            if (drain_r) begin
              if (end_r) begin
                in_row_nxt    = '0;
                in_col_nxt    = '0;
                drain_col_nxt = '0;
              end else begin
                drain_col_nxt = drain_col_r + 1'b1;
              end
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // a size write restarts the frame
    if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH: begin
          if (w_cfg_ext == '0) begin
            eff_w_nxt = WW'(1);
          end else if (w_cfg_ext > WCMP_W'(MAX_WIDTH)) begin
            eff_w_nxt = WW'(MAX_WIDTH);
          end else begin
            eff_w_nxt = WW'(w_cfg_ext);
          end
        end
        REG_FRAME_HEIGHT: begin
          if (h_cfg_ext == '0) begin
            eff_h_nxt = RW'(1);
          end else if (h_cfg_ext > HCMP_W'(MAX_HEIGHT)) begin
            eff_h_nxt = RW'(MAX_HEIGHT);
          end else begin
            eff_h_nxt = RW'(h_cfg_ext);
          end
        end
        default: begin
          eff_w_nxt = eff_w_r;
        end
      endcase
      in_row_nxt    = '0;
      in_col_nxt    = '0;
      drain_col_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_col_r    <= '0;
      in_row_r    <= '0;
      drain_col_r <= '0;
      eff_w_r     <= WW'(W_RST);
      eff_h_r     <= RW'(H_RST);
      emit_a_r    <= 1'b0;
      emit_b_r    <= 1'b0;
      drain_r     <= 1'b0;
      end_r       <= 1'b0;
      shift_en_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_col_r    <= in_col_nxt;
      in_row_r    <= in_row_nxt;
      drain_col_r <= drain_col_nxt;
      eff_w_r     <= eff_w_nxt;
      eff_h_r     <= eff_h_nxt;
      emit_a_r    <= emit_a_nxt;
      emit_b_r    <= emit_b_nxt;
      drain_r     <= drain_nxt;
      end_r       <= end_nxt;
      shift_en_r  <= shift_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r        <= px_nxt;
    col_r       <= col_nxt;
    row1_r      <= row1_nxt;
    row2_r      <= row2_nxt;
    col_lo_a_r  <= col_lo_a_nxt;
    col_lo_b_r  <= col_lo_b_nxt;
    row_lo_r    <= row_lo_nxt;
    fetch_col_r <= fetch_col_nxt;
    fetch_end_r <= fetch_end_nxt;
    window_r    <= window_nxt;
  end

  // ---------------------------------------------------------------- lanes
  for (genvar l = 0; l < NUM_CH; l++) begin : g_lane
    logic [CH_W-1:0] chan [WIN_CELLS];

    always_comb begin
      for (int i = 0; i < WIN_CELLS; i++) begin
        chan[i] = window_r[i][l];
      end
    end

    bbe_lane u_lane (
      .clk     (clk),
      .chan_in (chan),
      .mask    (win_mask),
      .cnt     (win_cnt),
      .quot    (quot[l])
    );
  end

  // ---------------------------------------------------------------- merge
  bbe_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .issue         (issue),
    .quot          (quot),
    .can_issue     (can_issue),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pix       (out_pix),
    .out_frame_end (out_frame_end)
  );

  assign out_red   = out_pix[CH_RED];
  assign out_green = out_pix[CH_GREEN];
  assign out_blue  = out_pix[CH_BLUE];

  // ---------------------------------------------------------------- checks
  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_col_r <= w_last)
    else $error("input column beyond frame width");

  a_row_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_row_r <= eff_h_r)
    else $error("input row beyond frame height");

  a_drain_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    drain_col_r <= w_last)
    else $error("drain column beyond frame width");

  a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (issue.valid && drain_r && end_r) |=> (in_row_r == '0 && drain_col_r == '0))
    else $error("frame not restarted after its last pixel");

endmodule

`default_nettype wire
